### hdl/kmc_pkg.sv
package kmc_pkg;

  localparam int DEF_MAX_POINTS   = 256;
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_FRAC_BITS    = 8;
  localparam int RESULT_CAP       = 16;

  localparam logic [2:0] OP_CLEAR         = 3'd0;
  localparam logic [2:0] OP_LOAD_POINT    = 3'd1;
  localparam logic [2:0] OP_LOAD_CENTROID = 3'd2;
  localparam logic [2:0] OP_RUN           = 3'd3;
  localparam logic [2:0] OP_QUERY         = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_ITER_LIMIT    = 1'b1;

  localparam logic [4:0] CLUSTER_COUNT_RST = 5'd8;
  localparam logic [7:0] ITER_LIMIT_RST    = 8'd64;

  localparam logic [23:0] C24_MAX = 24'h7FFFFF;
  localparam logic [23:0] C24_MIN = 24'h800000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRY,
    ST_RND_INIT,
    ST_PT_RD,
    ST_DIST,
    ST_DRAIN,
    ST_ACC,
    ST_UPD_ST,
    ST_UPD_WAIT,
    ST_UPD_WR,
    ST_RND_END,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

endpackage

### hdl/kmeans_clustering_engine_core.sv
// Lloyd k-means engine for 3D integer points.
// Input channel (item_valid/item_stall) carries op, coordinates and slot.
// Result channel (result_valid/result_stall) carries one cluster or status item.
// Config: APB, cluster_count at 0x0, iteration_limit at 0x4, pready always high.
// Clear and load centroid return nothing.
// Load point returns one item on the next cycle.
// Query reads the point's cluster from the assignment store, then registers one item.
// Run: each round walks the points one by one; for each point the steps are
// memory read, one cluster per cycle through the distance pipe, drain and
// accumulate. The update then runs the shared serial divider three times per
// non-empty cluster and writes that cluster's new centroid.
// After the last round the k cluster items stream out, one per cycle while the result is not stalled.
// A new item is taken only while the engine is idle and the result register
// is free or being emptied; a stalled result holds and blocks further items.
// Reset clears control, totals, sums and counts; point and centroid stores
// keep whatever they held and must be loaded before use.
module kmeans_clustering_engine_core #(
  parameter int MAX_POINTS   = kmc_pkg::DEF_MAX_POINTS,
  parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
  parameter int FRAC_BITS    = kmc_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         op,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [7:0]         slot_index,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         cluster_index,
  output logic signed [23:0] centroid_x,
  output logic signed [23:0] centroid_y,
  output logic signed [23:0] centroid_z,
  output logic [8:0]         member_count,
  output logic [7:0]         rounds_used,
  output logic               converged,
  output logic [1:0]         status,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kmc_pkg::*;

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = CW + 1;
  localparam int KMAX = (MAX_CLUSTERS < RESULT_CAP) ? MAX_CLUSTERS : RESULT_CAP;
  localparam int CENW = (16 + FRAC_BITS > 24) ? 16 + FRAC_BITS : 24;
  localparam int MW   = CENW + 1;
  localparam int SQW  = 2 * MW;
  localparam int DSW  = SQW + 2;
  localparam int SW   = (DSW > 64) ? DSW : 65;
  localparam int SUMW = 16 + PW;
  localparam int NUMW = SUMW + FRAC_BITS + 2;
  localparam int DENW = CNTW + 1;
  localparam int QW   = (NUMW > 25) ? NUMW : 25;

  // stores
  logic [47:0]             pt_mem [MAX_POINTS];
  logic [CW-1:0]           pc_mem [MAX_POINTS];
  logic signed [CENW-1:0]  cen_x [MAX_CLUSTERS];
  logic signed [CENW-1:0]  cen_y [MAX_CLUSTERS];
  logic signed [CENW-1:0]  cen_z [MAX_CLUSTERS];
  logic signed [SUMW-1:0]  sum_x [MAX_CLUSTERS];
  logic signed [SUMW-1:0]  sum_y [MAX_CLUSTERS];
  logic signed [SUMW-1:0]  sum_z [MAX_CLUSTERS];
  logic [CNTW-1:0]         cnt_t [MAX_CLUSTERS];

  // control
  state_t          state;
  state_t          state_next;
  logic [4:0]      cc;
  logic [7:0]      lim;
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] p;
  logic [KW-1:0]   ci;
  logic [KW-1:0]   ec;
  logic [KW-1:0]   uc;
  logic [KW-1:0]   k;
  logic [KW-1:0]   k_eff;
  axis_t           ax;
  logic [7:0]      rc;
  logic            conv;
  logic            changed;
  logic            s1_v;
  logic            s2_v;
  logic            s3_v;

  logic            acc;
  logic            out_free;
  logic [7:0]      lim_eff;
  logic [CNTW-1:0] total_ld;
  logic            full;
  logic [KW-1:0]   k1;
  logic [CW-1:0]   tix;

  // memory ports
  logic            pt_re;
  logic [PW-1:0]   pt_ra;
  logic [47:0]     pt_q;
  logic            pc_we;
  logic [PW-1:0]   pc_wa;
  logic [CW-1:0]   pc_wd;
  logic            pc_re;
  logic [PW-1:0]   pc_ra;
  logic [CW-1:0]   pc_q;
  logic [PW+7:0]   slot_ext;
  logic            q_ok;
  logic            q_hit;

  // distance pipe
  logic signed [15:0]   pt_x;
  logic signed [15:0]   pt_y;
  logic signed [15:0]   pt_z;
  logic signed [MW-1:0] px_s;
  logic signed [MW-1:0] py_s;
  logic signed [MW-1:0] pz_s;
  logic signed [MW-1:0] dx;
  logic signed [MW-1:0] dy;
  logic signed [MW-1:0] dz;
  logic [MW-1:0]        s1_ax;
  logic [MW-1:0]        s1_ay;
  logic [MW-1:0]        s1_az;
  logic                 s1_last;
  logic [CW-1:0]        s1_idx;
  logic [SQW-1:0]       s2_sx;
  logic [SQW-1:0]       s2_sy;
  logic [SQW-1:0]       s2_sz;
  logic                 s2_last;
  logic [CW-1:0]        s2_idx;
  logic [SW-1:0]        dsum;
  logic [63:0]          dsat;
  logic [63:0]          s3_d;
  logic                 s3_last;
  logic [CW-1:0]        s3_idx;
  logic [63:0]          best_d;
  logic [CW-1:0]        best_idx;

  // update
  logic                 div_start;
  logic                 div_done;
  logic [NUMW-1:0]      div_quo;
  logic [NUMW-1:0]      div_num;
  logic [DENW-1:0]      div_den;
  logic signed [SUMW-1:0] sel_sum;
  logic [SUMW-1:0]      sel_mag;
  logic                 div_neg;
  logic [QW-1:0]        qe;
  logic [23:0]          mean24;
  logic [23:0]          nv_x;
  logic [23:0]          nv_y;
  logic [23:0]          nv_z;
  logic signed [CENW-1:0] nvx_w;
  logic signed [CENW-1:0] nvy_w;
  logic signed [CENW-1:0] nvz_w;
  logic                 nv_diff;

  // result staging
  logic                   o_load;
  logic [CW-1:0]          o_idx;
  logic signed [CENW-1:0] o_cx;
  logic signed [CENW-1:0] o_cy;
  logic signed [CENW-1:0] o_cz;
  logic [CNTW-1:0]        o_cnt;
  logic                   o_run;
  logic [1:0]             o_status;
  logic                   o_last;
  logic [CW+3:0]          o_idx_ext;
  logic [CNTW+8:0]        o_cnt_ext;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_ITER_LIMIT) ? {24'b0, lim} : {27'b0, cc};

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == ST_IDLE) && out_free);
  assign acc        = item_valid && !item_stall;

  assign lim_eff  = (lim == 8'd0) ? 8'd1 : lim;
  assign full     = !(total < CNTW'(MAX_POINTS));
  assign total_ld = full ? total : total + 1'b1;
  assign k1       = k - 1'b1;
  assign slot_ext = (PW + 8)'(slot_index);
  assign q_hit    = (CNTW + 8)'(slot_index) < (CNTW + 8)'(total);

  always_comb begin
    if (cc == 5'd0) begin
      k_eff = KW'(1);
    end else if (cc > 5'(KMAX)) begin
      k_eff = KW'(KMAX);
    end else begin
      k_eff = KW'(cc);
    end
  end

  assign pt_x = $signed(pt_q[47:32]);
  assign pt_y = $signed(pt_q[31:16]);
  assign pt_z = $signed(pt_q[15:0]);
  assign px_s = MW'(pt_x) <<< FRAC_BITS;
  assign py_s = MW'(pt_y) <<< FRAC_BITS;
  assign pz_s = MW'(pt_z) <<< FRAC_BITS;
  assign dx   = px_s - MW'(cen_x[tix]);
  assign dy   = py_s - MW'(cen_y[tix]);
  assign dz   = pz_s - MW'(cen_z[tix]);
  assign dsum = SW'(s2_sx) + SW'(s2_sy) + SW'(s2_sz);
  assign dsat = (|dsum[SW-1:64]) ? '1 : dsum[63:0];

  always_comb begin
    unique case (ax)
      AX_X:    sel_sum = sum_x[tix];
      AX_Y:    sel_sum = sum_y[tix];
      default: sel_sum = sum_z[tix];
    endcase
  end
  assign sel_mag = sel_sum[SUMW-1] ? SUMW'(-sel_sum) : SUMW'(sel_sum);
  assign div_num = (NUMW'(sel_mag) << (FRAC_BITS + 1)) + NUMW'(cnt_t[tix]);
  assign div_den = DENW'(cnt_t[tix]) << 1;

  assign qe = QW'(div_quo);
  always_comb begin
    if (!div_neg) begin
      mean24 = (qe > QW'(C24_MAX)) ? C24_MAX : qe[23:0];
    end else begin
      mean24 = (qe > QW'(C24_MIN)) ? C24_MIN : 24'(-qe[23:0]);
    end
  end

  assign nvx_w   = CENW'($signed(nv_x));
  assign nvy_w   = CENW'($signed(nv_y));
  assign nvz_w   = CENW'($signed(nv_z));
  assign nv_diff = (nvx_w != cen_x[tix]) || (nvy_w != cen_y[tix]) ||
                   (nvz_w != cen_z[tix]);

  kmc_div #(
    .NUMW(NUMW),
    .DENW(DENW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && (op == OP_RUN) && (total != '0)) begin
          state_next = ST_RND_INIT;
        end else if (acc && (op == OP_QUERY)) begin
          state_next = ST_QRY;
        end
      end
      ST_QRY: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_RND_INIT: state_next = ST_PT_RD;
      ST_PT_RD:    state_next = ST_DIST;
      ST_DIST: begin
        if (ci == k1) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s3_v && s3_last) state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = (p == total - 1'b1) ? ST_UPD_ST : ST_PT_RD;
      end
      ST_UPD_ST: begin
        if (cnt_t[tix] != '0) begin
          state_next = ST_UPD_WAIT;
        end else if (uc == k1) begin
          state_next = ST_RND_END;
        end
      end
      ST_UPD_WAIT: begin
        if (div_done) state_next = (ax == AX_Z) ? ST_UPD_WR : ST_UPD_ST;
      end
      ST_UPD_WR: begin
        state_next = (uc == k1) ? ST_RND_END : ST_UPD_ST;
      end
      ST_RND_END: begin
        if (!changed || ({1'b0, rc} + 9'd1 >= {1'b0, lim_eff})) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_RND_INIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (ec == k1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pt_re     = 1'b0;
    pt_ra     = p[PW-1:0];
    pc_we     = 1'b0;
    pc_wa     = total[PW-1:0];
    pc_wd     = '0;
    pc_re     = 1'b0;
    pc_ra     = slot_ext[PW-1:0];
    div_start = 1'b0;
    o_load    = 1'b0;
    o_idx     = '0;
    o_cx      = '0;
    o_cy      = '0;
    o_cz      = '0;
    o_cnt     = '0;
    o_run     = 1'b0;
    o_status  = STATUS_OK;
    o_last    = 1'b1;
    unique case (state)
      ST_DIST:  tix = ci[CW-1:0];
      ST_ACC:   tix = best_idx;
      ST_EMIT:  tix = ec[CW-1:0];
      ST_QRY:   tix = pc_q;
      default:  tix = uc[CW-1:0];
    endcase
    unique case (state)
      ST_IDLE: begin
        if (acc && (op == OP_LOAD_POINT)) begin
          pc_we    = !full;
          o_load   = 1'b1;
          o_cnt    = total_ld;
          o_run    = 1'b1;
          o_status = full ? STATUS_FULL : STATUS_OK;
        end
        if (acc && (op == OP_RUN) && (total == '0)) begin
          o_load   = 1'b1;
          o_status = STATUS_NONE;
        end
        if (acc && (op == OP_QUERY)) begin
          pc_re = 1'b1;
        end
      end
      ST_QRY: begin
        o_load = out_free;
        if (q_ok) begin
          o_idx = pc_q;
          o_cx  = cen_x[tix];
          o_cy  = cen_y[tix];
          o_cz  = cen_z[tix];
          o_cnt = cnt_t[tix];
          o_run = 1'b1;
        end else begin
          o_status = STATUS_NONE;
        end
      end
      ST_PT_RD: pt_re = 1'b1;
      ST_ACC: begin
        pc_we = 1'b1;
        pc_wa = p[PW-1:0];
        pc_wd = best_idx;
      end
      ST_UPD_ST: div_start = (cnt_t[tix] != '0);
      ST_EMIT: begin
        o_load = out_free;
        o_idx  = ec[CW-1:0];
        o_cx   = cen_x[tix];
        o_cy   = cen_y[tix];
        o_cz   = cen_z[tix];
        o_cnt  = cnt_t[tix];
        o_run  = 1'b1;
        o_last = (ec == k1);
      end
      default: ;
    endcase
  end

  assign o_idx_ext = (CW + 4)'(o_idx);
  assign o_cnt_ext = (CNTW + 9)'(o_cnt);

  // memories
  always_ff @(posedge clk) begin
    if (acc && (op == OP_LOAD_POINT) && !full) begin
      pt_mem[total[PW-1:0]] <= {coord_x, coord_y, coord_z};
    end
    if (pt_re) begin
      pt_q <= pt_mem[pt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[pc_wa] <= pc_wd;
    end
    if (pc_re) begin
      pc_q <= pc_mem[pc_ra];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cc           <= CLUSTER_COUNT_RST;
      lim          <= ITER_LIMIT_RST;
      total        <= '0;
      p            <= '0;
      ci           <= '0;
      ec           <= '0;
      uc           <= '0;
      k            <= KW'(1);
      ax           <= AX_X;
      rc           <= '0;
      conv         <= 1'b0;
      changed      <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sum_x[i] <= '0;
        sum_y[i] <= '0;
        sum_z[i] <= '0;
        cnt_t[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_CLUSTER_COUNT) cc <= pwdata[4:0];
        else lim <= pwdata[7:0];
      end
      if (o_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      s1_v <= (state == ST_DIST);
      s2_v <= s1_v;
      s3_v <= s2_v;
      unique case (state)
        ST_IDLE: begin
          if (acc && (op == OP_CLEAR)) begin
            total <= '0;
            rc    <= '0;
            conv  <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              sum_x[i] <= '0;
              sum_y[i] <= '0;
              sum_z[i] <= '0;
              cnt_t[i] <= '0;
            end
          end
          if (acc && (op == OP_LOAD_POINT)) begin
            total <= total_ld;
          end
          if (acc && (op == OP_RUN) && (total != '0)) begin
            k    <= k_eff;
            rc   <= '0;
            conv <= 1'b0;
          end
        end
        ST_RND_INIT: begin
          p       <= '0;
          changed <= 1'b0;
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            if (KW'(i) < k) begin
              sum_x[i] <= '0;
              sum_y[i] <= '0;
              sum_z[i] <= '0;
              cnt_t[i] <= '0;
            end
          end
        end
        ST_PT_RD: ci <= '0;
        ST_DIST:  ci <= ci + 1'b1;
        ST_ACC: begin
          sum_x[tix] <= sum_x[tix] + SUMW'(pt_x);
          sum_y[tix] <= sum_y[tix] + SUMW'(pt_y);
          sum_z[tix] <= sum_z[tix] + SUMW'(pt_z);
          cnt_t[tix] <= cnt_t[tix] + 1'b1;
          p          <= p + 1'b1;
          uc         <= '0;
          ax         <= AX_X;
        end
        ST_UPD_ST: begin
          if ((cnt_t[tix] == '0) && (uc != k1)) uc <= uc + 1'b1;
        end
        ST_UPD_WAIT: begin
          if (div_done) begin
            unique case (ax)
              AX_X:    ax <= AX_Y;
              AX_Y:    ax <= AX_Z;
              default: ax <= AX_X;
            endcase
          end
        end
        ST_UPD_WR: begin
          changed <= changed | nv_diff;
          uc      <= uc + 1'b1;
        end
        ST_RND_END: begin
          rc <= rc + 1'b1;
          ec <= '0;
          if (!changed) conv <= 1'b1;
        end
        ST_EMIT: begin
          if (out_free) ec <= ec + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc && (op == OP_LOAD_CENTROID) && ({1'b0, slot_index} < 9'(MAX_CLUSTERS))) begin
      cen_x[slot_index[CW-1:0]] <= CENW'(coord_x) <<< FRAC_BITS;
      cen_y[slot_index[CW-1:0]] <= CENW'(coord_y) <<< FRAC_BITS;
      cen_z[slot_index[CW-1:0]] <= CENW'(coord_z) <<< FRAC_BITS;
    end
    if (acc && (op == OP_QUERY)) begin
      q_ok <= q_hit;
    end

    s1_ax   <= dx[MW-1] ? MW'(-dx) : MW'(dx);
    s1_ay   <= dy[MW-1] ? MW'(-dy) : MW'(dy);
    s1_az   <= dz[MW-1] ? MW'(-dz) : MW'(dz);
    s1_idx  <= ci[CW-1:0];
    s1_last <= (ci == k1);
    s2_sx   <= SQW'(s1_ax) * SQW'(s1_ax);
    s2_sy   <= SQW'(s1_ay) * SQW'(s1_ay);
    s2_sz   <= SQW'(s1_az) * SQW'(s1_az);
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s3_d    <= dsat;
    s3_idx  <= s2_idx;
    s3_last <= s2_last;
    if (s3_v && ((s3_idx == '0) || (s3_d < best_d))) begin
      best_d   <= s3_d;
      best_idx <= s3_idx;
    end

    if (div_start) begin
      div_neg <= sel_sum[SUMW-1];
    end
    if ((state == ST_UPD_WAIT) && div_done) begin
      unique case (ax)
        AX_X:    nv_x <= mean24;
        AX_Y:    nv_y <= mean24;
        default: nv_z <= mean24;
      endcase
    end
    if (state == ST_UPD_WR) begin
      cen_x[tix] <= nvx_w;
      cen_y[tix] <= nvy_w;
      cen_z[tix] <= nvz_w;
    end

    if (o_load) begin
      cluster_index <= o_idx_ext[3:0];
      centroid_x    <= o_cx[23:0];
      centroid_y    <= o_cy[23:0];
      centroid_z    <= o_cz[23:0];
      member_count  <= o_cnt_ext[8:0];
      rounds_used   <= o_run ? rc : 8'd0;
      converged     <= o_run & conv;
      status        <= o_status;
      last          <= o_last;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_UPD_WAIT))
    else $error("divider finished outside update wait");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> (KW'(best_idx) < k))
    else $error("nearest cluster beyond cluster count");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNTW'(MAX_POINTS))
    else $error("point total beyond store depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (ec < k))
    else $error("emit index beyond cluster count");

  a_drain_to_acc: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DRAIN) && s3_v && s3_last) |=> (state == ST_ACC))
    else $error("distance pipe drained without accumulate");

endmodule

### hdl/kmc_div.sv
module kmc_div #(
  parameter int NUMW = 34,
  parameter int DENW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CNTBW = $clog2(NUMW);
  localparam logic [CNTBW-1:0] LAST_STEP = CNTBW'(NUMW - 1);

  logic             busy;
  logic [CNTBW-1:0] cnt;
  logic [NUMW-1:0]  num_sh;
  logic [DENW-1:0]  rem;
  logic [DENW-1:0]  den_q;
  logic [DENW:0]    trial;
  logic [DENW:0]    diff;
  logic             ge;
  logic [DENW-1:0]  rem_next;

  assign trial    = {rem, num_sh[NUMW-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = trial >= {1'b0, den_q};
  assign rem_next = ge ? diff[DENW-1:0] : trial[DENW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      den_q  <= den;
    end else if (busy) begin
      num_sh <= {num_sh[NUMW-2:0], 1'b0};
      rem    <= rem_next;
      quo    <= {quo[NUMW-2:0], ge};
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import kmc_pkg::*;

  localparam int LIMIT_CYCLES = 40000000;
  localparam int SETTLE = 40;
  localparam int PHASE_ITEMS = 16;

  typedef struct packed {
    logic [3:0]         ci;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [8:0]         mc;
    logic [7:0]         ru;
    logic               cv;
    logic [1:0]         st;
    logic               lst;
  } result_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         slot;
    logic               typed;
    result_t            r;
  } row_t;

  localparam result_t NONE_R = '{4'd0, 24'sd0, 24'sd0, 24'sd0, 9'd0, 8'd0, 1'b0,
                                 STATUS_NONE, 1'b1};

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  logic [2:0] op = OP_CLEAR;
  logic signed [15:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic [7:0] slot_index = 0;
  logic result_valid;
  logic result_stall = 0;
  logic [3:0] cluster_index;
  logic signed [23:0] centroid_x, centroid_y, centroid_z;
  logic [8:0] member_count;
  logic [7:0] rounds_used;
  logic converged;
  logic [1:0] status;
  logic last;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  kmeans_clustering_engine_core dut (.*);

  // shadow of the engine
  longint pts[DEF_MAX_POINTS][3];
  logic [3:0] pt_cl[DEF_MAX_POINTS];
  int pt_total;
  longint cen[DEF_MAX_CLUSTERS][3];
  longint sums[DEF_MAX_CLUSTERS][3];
  int members[DEF_MAX_CLUSTERS];
  int rounds;
  bit conv;
  int k_reg = CLUSTER_COUNT_RST;
  int lim_reg = ITER_LIMIT_RST;

  result_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic result_t mk(int ci, longint x, longint y, longint z, int mc, int st,
                                 bit lst);
    result_t r;
    r.ci = 4'(ci); r.cx = 24'(x); r.cy = 24'(y); r.cz = 24'(z); r.mc = 9'(mc);
    r.ru = 8'(rounds); r.cv = conv; r.st = 2'(st); r.lst = lst;
    return r;
  endfunction

  function automatic longint unsigned sq_diff(longint p, longint c);
    longint d;
    longint unsigned m;
    d = p * 256 - c;
    m = d < 0 ? -d : d;
    return m * m;
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    return (a + b < a) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
  endfunction

  function automatic longint mean_fx(longint s, int n);
    longint unsigned mag, q;
    longint r;
    mag = s < 0 ? -s : s;
    q = ((mag << 8) * 2 + n) / (2 * n);
    r = q;
    if (s < 0) r = -r;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  function automatic bit lloyd_round(int k);
    bit changed;
    longint unsigned best, d;
    int bi;
    longint nv[3];
    changed = 0;
    for (int c = 0; c < k; c++) begin
      for (int a = 0; a < 3; a++) sums[c][a] = 0;
      members[c] = 0;
    end
    for (int p = 0; p < pt_total; p++) begin
      best = 0; bi = 0;
      for (int c = 0; c < k; c++) begin
        d = sq_diff(pts[p][0], cen[c][0]);
        d = sat_add(d, sq_diff(pts[p][1], cen[c][1]));
        d = sat_add(d, sq_diff(pts[p][2], cen[c][2]));
        if (c == 0 || d < best) begin
          best = d; bi = c;
        end
      end
      pt_cl[p] = 4'(bi);
      for (int a = 0; a < 3; a++) sums[bi][a] += pts[p][a];
      members[bi]++;
    end
    for (int c = 0; c < k; c++) begin
      if (members[c] != 0) begin
        for (int a = 0; a < 3; a++) nv[a] = mean_fx(sums[c][a], members[c]);
        if (nv[0] != cen[c][0] || nv[1] != cen[c][1] || nv[2] != cen[c][2]) changed = 1;
        for (int a = 0; a < 3; a++) cen[c][a] = nv[a];
      end
    end
    return changed;
  endfunction

  function automatic void model_item(logic [2:0] o, logic signed [15:0] x,
                                     logic signed [15:0] y, logic signed [15:0] z,
                                     logic [7:0] slot, bit emit);
    result_t out[$];
    int k, lim, st, c;
    bit cs;
    case (o)
      OP_CLEAR: begin
        pt_total = 0;
        for (int i = 0; i < DEF_MAX_CLUSTERS; i++) begin
          for (int a = 0; a < 3; a++) sums[i][a] = 0;
          members[i] = 0;
        end
        rounds = 0; conv = 0;
      end
      OP_LOAD_POINT: begin
        st = STATUS_FULL;
        if (pt_total < DEF_MAX_POINTS) begin
          pts[pt_total][0] = x; pts[pt_total][1] = y; pts[pt_total][2] = z;
          pt_cl[pt_total] = 0;
          pt_total++;
          st = STATUS_OK;
        end
        out = {out, mk(0, 0, 0, 0, pt_total, st, 1)};
      end
      OP_LOAD_CENTROID: begin
        if (slot < DEF_MAX_CLUSTERS) begin
          cen[slot][0] = x * 256; cen[slot][1] = y * 256; cen[slot][2] = z * 256;
        end
      end
      OP_RUN: begin
        if (pt_total == 0) out = {out, NONE_R};
        else begin
          k = k_reg; lim = lim_reg;
          if (k < 1) k = 1;
          if (k > DEF_MAX_CLUSTERS) k = DEF_MAX_CLUSTERS;
          if (lim < 1) lim = 1;
          rounds = 0; conv = 0;
          while (rounds < lim) begin
            cs = lloyd_round(k);
            rounds++;
            if (!cs) begin
              conv = 1;
              break;
            end
          end
          for (c = 0; c < k; c++)
            out = {out, mk(c, cen[c][0], cen[c][1], cen[c][2], members[c], STATUS_OK,
                           c + 1 == k)};
        end
      end
      OP_QUERY: begin
        if (slot < pt_total) begin
          c = pt_cl[slot];
          out = {out, mk(c, cen[c][0], cen[c][1], cen[c][2], members[c], STATUS_OK, 1)};
        end else out = {out, NONE_R};
      end
      default: ;
    endcase
    if (emit) pending_q = {pending_q, out};
  endfunction

  function automatic void cmp(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) result_stall <= 0;
    else result_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual cluster %0d status %0d",
                 $time, cluster_index, status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        cmp("cluster_index", e.ci, cluster_index);
        cmp("centroid_x", e.cx, centroid_x);
        cmp("centroid_y", e.cy, centroid_y);
        cmp("centroid_z", e.cz, centroid_z);
        cmp("member_count", e.mc, member_count);
        cmp("rounds_used", e.ru, rounds_used);
        cmp("converged", e.cv, converged);
        cmp("status", e.st, status);
        cmp("last", e.lst, last);
      end
    end
  end

  task automatic send(logic [2:0] o, logic signed [15:0] x, logic signed [15:0] y,
                      logic signed [15:0] z, logic [7:0] slot, bit typed = 0,
                      result_t r = NONE_R);
    if ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1;
    op <= o; coord_x <= x; coord_y <= y; coord_z <= z; slot_index <= slot;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    model_item(o, x, y, z, slot, !typed);
    if (typed) pending_q = {pending_q, r};
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic addr_bit, int val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {addr_bit, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr_bit == REG_CLUSTER_COUNT) k_reg = val & 32'h1F;
    else lim_reg = val & 32'hFF;
  endtask

  function automatic logic signed [15:0] near(int ctr, int spread);
    int v;
    v = ctr + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic cluster_job(int n);
    int ctr[4][3];
    int spread, nc, c;
    nc = $urandom_range(1, 4);
    spread = $urandom_range(0, 3) == 0 ? 20000 : $urandom_range(0, 600);
    for (int i = 0; i < nc; i++)
      for (int a = 0; a < 3; a++) ctr[i][a] = $signed(16'($urandom));
    if ($urandom_range(0, 9) != 0) send(OP_CLEAR, 16'($urandom), 16'($urandom),
                                        16'($urandom), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, nc - 1);
      send(OP_LOAD_POINT, near(ctr[c][0], spread), near(ctr[c][1], spread),
           near(ctr[c][2], spread), 8'($urandom));
    end
    repeat ($urandom_range(0, 3)) begin
      c = $urandom_range(0, nc - 1);
      send(OP_LOAD_CENTROID, near(ctr[c][0], 2 * spread), near(ctr[c][1], 2 * spread),
           near(ctr[c][2], 2 * spread), $urandom_range(0, 3) == 0 ? 8'($urandom) :
           8'($urandom_range(0, 15)));
    end
    send(OP_RUN, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    repeat ($urandom_range(1, 4))
      send(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
           $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, pt_total)));
  endtask

  row_t dir_tab[] = '{
    '{OP_RUN, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1, NONE_R},
    '{OP_LOAD_POINT, 16'sd32767, 16'sd32767, 16'sd32767, 8'd0, 1'b1,
      '{4'd0, 24'sd0, 24'sd0, 24'sd0, 9'd1, 8'd0, 1'b0, STATUS_OK, 1'b1}},
    '{OP_LOAD_POINT, -16'sd32768, -16'sd32768, -16'sd32768, 8'd255, 1'b1,
      '{4'd0, 24'sd0, 24'sd0, 24'sd0, 9'd2, 8'd0, 1'b0, STATUS_OK, 1'b1}},
    '{OP_LOAD_POINT, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1,
      '{4'd0, 24'sd0, 24'sd0, 24'sd0, 9'd3, 8'd0, 1'b0, STATUS_OK, 1'b1}},
    '{OP_LOAD_CENTROID, -16'sd32768, 16'sd5, 16'sd5, 8'd255, 1'b0, NONE_R},
    '{OP_LOAD_CENTROID, 16'sd32767, -16'sd32768, 16'sd0, 8'd0, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd1, 1'b0, NONE_R},
    '{OP_RUN, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd1, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd2, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd3, 1'b1, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd255, 1'b1, NONE_R},
    '{3'd5, 16'sd1, 16'sd1, 16'sd1, 8'd1, 1'b0, NONE_R},
    '{3'd6, 16'sd1, 16'sd1, 16'sd1, 8'd1, 1'b0, NONE_R},
    '{3'd7, -16'sd1, -16'sd1, -16'sd1, 8'd255, 1'b0, NONE_R},
    '{OP_CLEAR, -16'sd1, -16'sd1, -16'sd1, 8'd255, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1, NONE_R},
    '{OP_RUN, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1, NONE_R},
    '{OP_LOAD_POINT, 16'sd1, 16'sd2, 16'sd3, 8'd0, 1'b1,
      '{4'd0, 24'sd0, 24'sd0, 24'sd0, 9'd1, 8'd0, 1'b0, STATUS_OK, 1'b1}},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NONE_R},
    '{OP_RUN, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NONE_R},
    '{OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, NONE_R}
  };

  int idle_set[4] = '{0, 53, 0, 30};
  int stall_set[4] = '{0, 0, 53, 30};
  int k_set[6] = '{8, 1, 16, 0, 31, 5};
  int lim_set[6] = '{64, 1, 255, 0, 3, 10};

  initial begin
    int start;
    rst <= 1;
    pt_total = 0; rounds = 0; conv = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int s = 0; s < DEF_MAX_CLUSTERS; s++)
      send(OP_LOAD_CENTROID, 16'($urandom), 16'($urandom), 16'($urandom), 8'(s));
    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].slot,
           dir_tab[i].typed, dir_tab[i].r);

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = idle_set[ph % 4];
      stall_pct = stall_set[ph % 4];
      if (ph > 0) begin
        drain();
        write_reg(REG_CLUSTER_COUNT, k_set[ph]);
        write_reg(REG_ITER_LIMIT, lim_set[ph]);
      end
      if (ph == 1) begin
        // fill the point store, then overflow it
        send(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i <= DEF_MAX_POINTS; i++)
          send(OP_LOAD_POINT, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        send(OP_RUN, 0, 0, 0, 0);
        send(OP_QUERY, 0, 0, 0, 8'd255);
        send(OP_QUERY, 0, 0, 0, 8'd0);
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0)
          send(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        else cluster_job($urandom_range(0, 5) == 0 ? $urandom_range(13, 30) :
                         $urandom_range(1, 12));
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hdl/kmc_pkg.sv
hdl/kmc_div.sv
hdl/kmeans_clustering_engine_core.sv
bench/tb.sv
